[hdl/met_pkg.sv]
// Shared types, constants and helpers for the Mandelbrot escape-time core.
// Used by mandelbrot_escape_time_core and its bench; depends on nothing.
`default_nettype none
package met_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;
  localparam int FRAC_OUT   = 16;

  localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COUNT_BITS + 2 * FRAC_OUT + 7) / 8) * 8;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_MIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG_MIN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_STEP = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG_STEP = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd5;

  localparam logic [COUNT_BITS-1:0] COUNT_CAP = {{(COUNT_BITS-1){1'b1}}, 1'b0};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CI,
    ST_BOUND,
    ST_CMAG_R,
    ST_CMAG_I,
    ST_CMAG_SUM,
    ST_SQRT_C,
    ST_SQ_R,
    ST_SQ_I,
    ST_CROSS,
    ST_UPD,
    ST_SQRT_Z,
    ST_DONE
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/met_isqrt.sv]
// Bit-serial integer square root of a 64-bit radicand, two radicand bits a cycle.
// Depends on nothing outside this file.
`default_nettype none
module met_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitm;
  logic        active;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && bitm[0]) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      res  <= '0;
      bitm <= 64'h4000_0000_0000_0000;
    end else if (active) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule
`default_nettype wire

[hdl/mandelbrot_escape_time_core.sv]
// Top level of the Mandelbrot escape-time core: sequencer, shared multiplier, registers.
// Depends on met_pkg and met_isqrt.
//
// Usage: each word on the s_ channel names one pixel by column and row. The core maps
// it to c in signed Q4.28, iterates z = z*z + c from z = 0 and returns one word on the
// m_ channel with the coordinates, the iteration count, the escaped flag (m_tuser) and
// the Q0.16 fractions of the final |z| and of |c|.
// Registers must be written by the user on the cfg_ channel only while the core is idle;
// the core itself does not enforce this. cfg_ready is always high and an index beyond
// the register list is ignored. One 33x33 multiplier is shared by every product, and
// both square roots (of |c|^2 and of the final |z|^2) run on the bit-serial root unit.
// One pixel is in work at a time; s_tready is high only between pixels.
// The result sits in an output register, so a new pixel is accepted while the previous
// result still waits; if the receiver stalls longer, the core holds the finished
// result internally until the output register frees up.
// Reset (rst, synchronous) restores the default view, drops any pixel in work and
// clears m_tvalid.
`default_nettype none
module mandelbrot_escape_time_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // column, row
  input  wire logic [met_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // out_column, out_row, iteration_count, modulus_fraction, point_magnitude_fraction
  output logic [met_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  // escaped
  output logic                                     m_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [met_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [31:0]                         cfg_data
);
  import met_pkg::*;

  state_t state, state_next;

  logic signed [31:0] real_min, imag_min;
  logic [30:0]        real_step, imag_step, bail_radius;
  logic [15:0]        max_iterations;

  coord_t             col, row;
  logic [31:0]        cr, ci, zr, zi;
  logic [63:0]        bound, sq_r;
  logic signed [63:0] diff;
  logic signed [63:0] p;
  count_t             k;
  logic               esc;
  logic [FRAC_OUT-1:0] frac_c, frac_z;

  coord_t              o_col, o_row;
  count_t              o_count;
  logic                o_esc;
  logic [FRAC_OUT-1:0] o_frac_z, o_frac_c;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic [31:0]        er_p1;
  count_t             limit;
  logic [63:0]        radicand;
  logic               is_esc, leave, sqrt_start, sqrt_done, out_load;
  logic [31:0]        sqrt_root;

  assign cfg_ready = 1'b1;
  assign er_p1     = {1'b0, bail_radius} + 32'd1;
  assign limit     = (max_iterations[COUNT_BITS-1:0] > COUNT_CAP) ? COUNT_CAP
                                                                 : max_iterations[COUNT_BITS-1:0];
  assign radicand  = sq_r + p;
  assign is_esc    = radicand >= bound;
  assign leave     = is_esc || (k > limit);
  assign mul_full  = mul_a * mul_b;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  met_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_CR;
      ST_CR:       state_next = ST_CI;
      ST_CI:       state_next = ST_BOUND;
      ST_BOUND:    state_next = ST_CMAG_R;
      ST_CMAG_R:   state_next = ST_CMAG_I;
      ST_CMAG_I:   state_next = ST_CMAG_SUM;
      ST_CMAG_SUM: state_next = ST_SQRT_C;
      ST_SQRT_C:   if (sqrt_done) state_next = ST_SQ_R;
      ST_SQ_R:     state_next = ST_SQ_I;
      ST_SQ_I:     state_next = ST_CROSS;
      ST_CROSS:    state_next = leave ? ST_SQRT_Z : ST_UPD;
      ST_UPD:      state_next = ST_SQ_R;
      ST_SQRT_Z:   if (sqrt_done) state_next = ST_DONE;
      ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE:     s_tready = 1'b1;
      ST_CR: begin
        mul_a = $signed(33'(col));
        mul_b = $signed({2'b00, real_step});
      end
      ST_CI: begin
        mul_a = $signed(33'(row));
        mul_b = $signed({2'b00, imag_step});
      end
      ST_BOUND: begin
        mul_a = $signed({1'b0, er_p1});
        mul_b = $signed({1'b0, er_p1});
      end
      ST_CMAG_R: begin
        mul_a = $signed({cr[31], cr});
        mul_b = $signed({cr[31], cr});
      end
      ST_CMAG_I: begin
        mul_a = $signed({ci[31], ci});
        mul_b = $signed({ci[31], ci});
      end
      ST_CMAG_SUM: sqrt_start = 1'b1;
      ST_SQ_R: begin
        mul_a = $signed({zr[31], zr});
        mul_b = $signed({zr[31], zr});
      end
      ST_SQ_I: begin
        mul_a = $signed({zi[31], zi});
        mul_b = $signed({zi[31], zi});
      end
      ST_CROSS: begin
        mul_a      = $signed({zr[31], zr});
        mul_b      = $signed({zi[31], zi});
        sqrt_start = leave;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      real_min       <= -32'sd536870912;
      imag_min       <= -32'sd536870912;
      real_step      <= 31'd1342177;
      imag_step      <= 31'd1342177;
      bail_radius    <= 31'd536870912;
      max_iterations <= 16'd200;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REAL_MIN:  real_min       <= $signed(cfg_data);
          CFG_IMAG_MIN:  imag_min       <= $signed(cfg_data);
          CFG_REAL_STEP: real_step      <= cfg_data[30:0];
          CFG_IMAG_STEP: imag_step      <= cfg_data[30:0];
          CFG_RADIUS:    bail_radius    <= cfg_data[30:0];
          CFG_MAX_ITER:  max_iterations <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= mul_full[63:0];
    case (state)
      ST_IDLE: begin
        col <= s_tdata[COORD_BITS-1:0];
        row <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      ST_CI:       cr <= sat32(64'(real_min) + p);
      ST_BOUND:    ci <= sat32(64'(imag_min) + p);
      ST_CMAG_R:   bound <= p;
      ST_CMAG_I:   sq_r <= p;
      ST_SQRT_C: begin
        frac_c <= sqrt_root[FRAC_BITS-1 -: FRAC_OUT];
        zr     <= '0;
        zi     <= '0;
        k      <= '0;
      end
      ST_SQ_I:     sq_r <= p;
      ST_CROSS: begin
        diff <= $signed(sq_r) - p;
        esc  <= is_esc;
      end
      ST_UPD: begin
        zr <= sat32((diff >>> FRAC_BITS) + 64'($signed(cr)));
        zi <= sat32((p >>> (FRAC_BITS - 1)) + 64'($signed(ci)));
        k  <= k + 1'b1;
      end
      ST_SQRT_Z:   frac_z <= sqrt_root[FRAC_BITS-1 -: FRAC_OUT];
      default: begin
      end
    endcase
    if (out_load) begin
      o_col    <= col;
      o_row    <= row;
      o_count  <= k;
      o_esc    <= esc;
      o_frac_z <= frac_z;
      o_frac_c <= frac_c;
    end
  end

  assign m_tdata = OUT_DATA_BITS'({o_frac_c, o_frac_z, o_count, o_row, o_col});
  assign m_tuser = o_esc;

  a_root_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_SQRT_C || state == ST_SQRT_Z))
    else $error("square root finished outside a wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_CR))
    else $error("accepted pixel did not start the setup sequence");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CROSS) |-> ({1'b0, k} <= {1'b0, limit} + 1'b1))
    else $error("iteration count ran past the limit");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (k != '0))
    else $error("result delivered with no iteration done");

endmodule
`default_nettype wire

[bench/mandelbrot_escape_time_core_tb.sv]
// Self-checking bench for mandelbrot_escape_time_core: directed table, then random views.
// Each accepted pixel word is compared with a known row or an in-bench escape-time model.
// Depends on met_pkg and the core RTL.
`default_nettype none
module mandelbrot_escape_time_core_tb;
  import met_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;
  localparam int Q_ONE = 268435456;
  localparam int Q_TWO = 536870912;

  typedef struct packed {
    logic [15:0] mag_frac;
    logic [15:0] mod_frac;
    logic        escaped;
    count_t      count;
    coord_t      row;
    coord_t      col;
  } pixel_result_t;

  typedef struct {
    bit                      is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [31:0]             data;
    coord_t                  col;
    coord_t                  row;
    bit                      known;
    pixel_result_t           want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mandelbrot_escape_time_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  int          re_origin  = -536870912;
  int          im_origin  = -536870912;
  logic [30:0] re_pitch   = 31'd1342177;
  logic [30:0] im_pitch   = 31'd1342177;
  logic [30:0] radius     = 31'd536870912;
  count_t      iter_limit = 16'd200;

  pixel_result_t pending_pixels[$];
  plan_row_t     plan[$];
  int            mismatch_count = 0;
  bit            calm = 1'b0;

  function automatic longint clamp_q4_28(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint unsigned square_mag(input longint v);
    longint unsigned a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic pixel_result_t escape_time(input coord_t col, input coord_t row);
    pixel_result_t r;
    longint cr, ci, zr, zi;
    longint unsigned mag2, bound, lim, root;
    int unsigned k;
    bit esc;
    lim = iter_limit;
    if (iter_limit > COUNT_CAP) lim = COUNT_CAP;
    bound = (longint'(radius) + 1) * (longint'(radius) + 1);
    cr = clamp_q4_28(longint'(re_origin) + longint'(col) * longint'(re_pitch));
    ci = clamp_q4_28(longint'(im_origin) + longint'(row) * longint'(im_pitch));
    zr = 0;
    zi = 0;
    mag2 = 0;
    k = 0;
    esc = 1'b0;
    while (!esc && k <= lim) begin
      longint nr, ni;
      nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
      ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
      zr = clamp_q4_28(nr);
      zi = clamp_q4_28(ni);
      mag2 = square_mag(zr) + square_mag(zi);
      esc = (mag2 >= bound);
      k++;
    end
    r.col = col;
    r.row = row;
    r.count = k[COUNT_BITS-1:0];
    r.escaped = esc;
    root = floor_root(mag2);
    r.mod_frac = root[FRAC_BITS-1 -: 16];
    root = floor_root(square_mag(cr) + square_mag(ci));
    r.mag_frac = root[FRAC_BITS-1 -: 16];
    return r;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] d);
    case (idx)
      CFG_REAL_MIN:  re_origin = d;
      CFG_IMAG_MIN:  im_origin = d;
      CFG_REAL_STEP: re_pitch = d[30:0];
      CFG_IMAG_STEP: im_pitch = d[30:0];
      CFG_RADIUS:    radius = d[30:0];
      CFG_MAX_ITER:  iter_limit = d[COUNT_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic string show(input pixel_result_t p);
    return $sformatf("col %0d row %0d count %0d esc %0d mod_frac %h mag_frac %h",
                     p.col, p.row, p.count, p.escaped, p.mod_frac, p.mag_frac);
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] d);
    plan_row_t e;
    e = '{default: '0};
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.data = d;
    plan.push_back(e);
  endfunction

  function automatic void plan_pixel(input coord_t col, input coord_t row);
    plan_row_t e;
    e = '{default: '0};
    e.col = col;
    e.row = row;
    plan.push_back(e);
  endfunction

  // Known rows all land on exact moduli, so both fractions are zero.
  function automatic void plan_known(input coord_t col, input coord_t row,
                                     input count_t count, input logic esc);
    plan_row_t e;
    e = '{default: '0};
    e.col = col;
    e.row = row;
    e.known = 1'b1;
    e.want = '{mag_frac: 16'h0, mod_frac: 16'h0, escaped: esc, count: count,
               row: row, col: col};
    plan.push_back(e);
  endfunction

  always @(posedge clk) begin
    pixel_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.col = m_tdata[11:0];
      got.row = m_tdata[23:12];
      got.count = m_tdata[39:24];
      got.mod_frac = m_tdata[55:40];
      got.mag_frac = m_tdata[71:56];
      got.escaped = m_tuser;
      if (pending_pixels.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected word: %s", $realtime, show(got));
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                     $realtime, show(want), show(got));
          mismatch_count++;
        end
      end
    end
    m_tready <= calm || ($urandom_range(0, 99) >= 27);
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, d);
  endtask

  task automatic send_pixel(input coord_t col, input coord_t row, input bit known,
                            input pixel_result_t want);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_BITS'({row, col});
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(known ? want : escape_time(col, row));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    coord_t c;
    if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 1) ? '1 : '0;
    else c = coord_t'($urandom_range(0, 4095));
    return c;
  endfunction

  initial begin
    pixel_result_t none;
    logic [31:0] rmin, imin, rstep, istep, rad, lim;
    none = '0;

    // Default view after reset.
    plan_pixel(12'd0, 12'd0);
    plan_pixel(12'd4095, 12'd4095);
    plan_pixel(12'd400, 12'd400);
    plan_pixel(12'd4095, 12'd0);
    plan_pixel(12'd0, 12'd4095);
    // c = 0: z never moves, so the loop runs to the limit.
    plan_cfg(CFG_REAL_MIN, 32'd0);
    plan_cfg(CFG_IMAG_MIN, 32'd0);
    plan_cfg(CFG_REAL_STEP, 32'd0);
    plan_cfg(CFG_IMAG_STEP, 32'd0);
    plan_cfg(CFG_MAX_ITER, 32'd0);
    plan_known(12'd123, 12'd456, 16'd1, 1'b0);
    // A limit above the cap is cut to the cap, so the count reaches all ones.
    plan_cfg(CFG_MAX_ITER, 32'h0000_ffff);
    plan_known(12'd4095, 12'd4095, 16'hffff, 1'b0);
    // c = 1: z goes 1, 2, 5 and escapes on the pass that also passes the limit.
    plan_cfg(CFG_REAL_MIN, Q_ONE);
    plan_cfg(CFG_MAX_ITER, 32'd2);
    plan_known(12'd7, 12'd9, 16'd3, 1'b1);
    plan_cfg(CFG_MAX_ITER, 32'd1);
    plan_known(12'd7, 12'd9, 16'd2, 1'b0);
    plan_cfg(CFG_RADIUS, 32'd0);
    plan_known(12'd4095, 12'd0, 16'd1, 1'b1);
    // Extreme origins and the largest steps drive both parts of c into saturation.
    plan_cfg(CFG_RADIUS, 32'h7fff_ffff);
    plan_cfg(CFG_MAX_ITER, 32'd30);
    plan_cfg(CFG_REAL_MIN, 32'h7fff_ffff);
    plan_cfg(CFG_IMAG_MIN, 32'h8000_0000);
    plan_cfg(CFG_REAL_STEP, 32'hffff_ffff);
    plan_cfg(CFG_IMAG_STEP, 32'h7fff_ffff);
    plan_pixel(12'd4095, 12'd4095);
    plan_pixel(12'd0, 12'd0);
    plan_pixel(12'd0, 12'd4095);
    // Writes to indexes past the register list must change nothing.
    plan_cfg(CFG_SPARE_6, 32'hffff_ffff);
    plan_cfg(CFG_SPARE_7, 32'h5a5a_5a5a);
    plan_pixel(12'd4095, 12'd0);
    plan_cfg(CFG_REAL_MIN, 32'he000_0000);
    plan_cfg(CFG_IMAG_MIN, 32'hf000_0000);
    plan_cfg(CFG_REAL_STEP, 32'd196608);
    plan_cfg(CFG_IMAG_STEP, 32'd131072);
    plan_cfg(CFG_RADIUS, Q_TWO);
    plan_cfg(CFG_MAX_ITER, 32'd65534);
    plan_pixel(12'd0, 12'd0);
    plan_cfg(CFG_MAX_ITER, 32'd24);
    plan_pixel(12'd2730, 12'd2048);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < plan.size(); n++) begin
      if (plan[n].is_cfg) begin
        if (n == 0 || !plan[n-1].is_cfg) wait_idle();
        write_reg(plan[n].idx, plan[n].data);
        if (n + 1 == plan.size() || !plan[n+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_pixel(plan[n].col, plan[n].row, plan[n].known, plan[n].want);
      end
    end

    for (int phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        rmin = $urandom;
        imin = $urandom;
        rstep = $urandom;
        istep = $urandom;
        rad = $urandom;
      end else begin
        rmin = -671088640 + int'($urandom_range(0, 805306368));
        imin = -402653184 + int'($urandom_range(0, 536870912));
        rstep = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 300000))};
        istep = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 300000))};
        rad = ($urandom_range(0, 2) == 0) ? $urandom : Q_TWO;
      end
      lim = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 300) : $urandom_range(0, 64);
      lim[31:16] = $urandom_range(0, 65535);
      wait_idle();
      write_reg(CFG_REAL_MIN, rmin);
      write_reg(CFG_IMAG_MIN, imin);
      write_reg(CFG_REAL_STEP, rstep);
      write_reg(CFG_IMAG_STEP, istep);
      write_reg(CFG_RADIUS, rad);
      write_reg(CFG_MAX_ITER, lim);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
      cfg_valid <= 1'b0;
      calm = (phase == 3);
      for (int i = 0; i < 50; i++) begin
        if (i == 25 && phase == 5 || $urandom_range(0, 59) == 0) wait_idle();
        send_pixel(pick_coord(), pick_coord(), 1'b0, none);
      end
      calm = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
